>>> design/dqe_pkg.sv
// Package for the bounded deque engine: sizes, command codes and the
// control bundle broadcast to every storage cell. No dependencies.
`default_nettype none
package dqe_pkg;

  localparam int DEPTH   = 16;
  localparam int WIDTH   = 32;
  localparam int POS_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OP_W    = 3;
  localparam int INDEX_W = 4;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;
  localparam logic [OP_W-1:0] OP_READ       = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd7;

  // Strobes are already qualified with the transfer; the push and front-pop strobes also with the full/empty checks.
  typedef struct packed {
    logic               shift_in;   // push front: take the left neighbor's word
    logic               write_rear; // push rear: the cell at count takes the value
    logic               shift_out;  // pop front: take the right neighbor's word
    logic               del;        // delete: cells at and after the match shift
    logic [WIDTH-1:0]   value;
    logic [INDEX_W-1:0] index;
    logic [CNT_W-1:0]   count;      // count before the command
    logic [CNT_W-1:0]   count_new;  // count after the command
  } dqe_ctrl_t;

endpackage
`default_nettype wire

>>> design/dqe_cell.sv
// One storage cell of the deque chain; cell 0 holds the front element.
// Depends on dqe_pkg.
`default_nettype none
module dqe_cell
  import dqe_pkg::*;
(
  input  wire logic             clk,
  input  wire dqe_ctrl_t        ctrl,
  input  wire logic [POS_W-1:0] pos,        // this cell's place from the front
  input  wire logic [WIDTH-1:0] left_data,  // current word of the cell nearer the front
  input  wire logic [WIDTH-1:0] right_data, // current word of the cell nearer the rear
  input  wire logic             found_in,   // a match exists nearer the front
  output logic                  found_out,
  output logic [WIDTH-1:0]      data_q,
  output logic [WIDTH-1:0]      data_next,
  output logic [WIDTH-1:0]      read_part,
  output logic [WIDTH-1:0]      rear_part
);

  logic [WIDTH-1:0] data_r;
  logic [WIDTH-1:0] data_nxt;
  logic [CNT_W-1:0] pos_ext;
  logic             live;

  assign pos_ext   = CNT_W'(pos);
  assign live      = pos_ext < ctrl.count;
  assign found_out = found_in | (live && (data_r == ctrl.value));

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_in) begin
      data_nxt = left_data;
    end else if (ctrl.write_rear && (ctrl.count == pos_ext)) begin
      data_nxt = ctrl.value;
    end else if (ctrl.shift_out || (ctrl.del && found_out)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q    = data_r;
  assign data_next = data_nxt;
  assign read_part = (live && (pos_ext == CNT_W'(ctrl.index))) ? data_r : '0;
  assign rear_part = ((pos_ext + CNT_W'(1)) == ctrl.count_new) ? data_nxt : '0;

endmodule
`default_nettype wire

>>> design/bounded_deque_engine_unit.sv
// Bounded deque engine: a chain of DEPTH cells ordered from front to rear.
// An input transfer's result is in the output register in the cycle after the transfer.
// Throughput: one command per cycle while results are taken; the input is held
// off only while an untaken result sits in the output register.
// Reset (synchronous, rst_n low) empties the deque and drops any pending result;
// cell contents are not cleared, since only live cells are ever observed.
// Depends on dqe_pkg and dqe_cell.
`default_nettype none
module bounded_deque_engine_unit
  import dqe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // op[2:0], value[34:3], index[38:35], zero[39]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata   // ok[0], read_value[32:1], front_value[64:33],
                                        // rear_value[96:65], count[101:97],
                                        // empty_res[102], zero[103]
);

  logic [OP_W-1:0]    op;
  logic [WIDTH-1:0]   value;
  logic [INDEX_W-1:0] index;
  logic               accept;

  assign op     = in_tdata[2:0];
  assign value  = in_tdata[34:3];
  assign index  = in_tdata[38:35];
  // A new command is taken whenever the output register is free or draining.
  assign in_tready = !out_tvalid || out_tready;
  assign accept    = in_tvalid && in_tready;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             full;
  logic             is_empty;
  logic             found;
  logic             ok;
  dqe_ctrl_t        ctrl;

  assign full     = count_r == CNT_W'(DEPTH);
  assign is_empty = count_r == '0;

  // Command decode; the match search result comes back from the end of the chain.
  always_comb begin
    count_nxt = count_r;
    ok        = 1'b0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (!full) begin
          count_nxt = count_r + CNT_W'(1);
          ok        = 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (!is_empty) begin
          count_nxt = count_r - CNT_W'(1);
          ok        = 1'b1;
        end
      end
      OP_DELETE: begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
          ok        = 1'b1;
        end
      end
      OP_READ: begin
        ok = CNT_W'(index) < count_r;
      end
      OP_CLEAR: begin
        count_nxt = '0;
        ok        = 1'b1;
      end
      OP_PEEK: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctrl.shift_in   = accept && (op == OP_PUSH_FRONT) && !full;
    ctrl.write_rear = accept && (op == OP_PUSH_REAR) && !full;
    ctrl.shift_out  = accept && (op == OP_POP_FRONT) && !is_empty;
    ctrl.del        = accept && (op == OP_DELETE);
    ctrl.value      = value;
    ctrl.index      = index;
    ctrl.count      = count_r;
    ctrl.count_new  = count_nxt;
  end

  // The cell chain. Words move one cell toward the rear on a front push and one
  // cell toward the front on a front pop or behind a deleted match.
  logic [WIDTH-1:0] cell_q    [DEPTH];
  logic [WIDTH-1:0] cell_next [DEPTH];
  logic [WIDTH-1:0] read_part [DEPTH];
  logic [WIDTH-1:0] rear_part [DEPTH];
  logic             found_chain [DEPTH+1];

  assign found_chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WIDTH-1:0] left_w;
    logic [WIDTH-1:0] right_w;
    if (g == 0) begin : g_head
      assign left_w = value;
    end else begin : g_body
      assign left_w = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w = cell_q[g];
    end else begin : g_mid
      assign right_w = cell_q[g+1];
    end
    dqe_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (POS_W'(g)),
      .left_data  (left_w),
      .right_data (right_w),
      .found_in   (found_chain[g]),
      .found_out  (found_chain[g+1]),
      .data_q     (cell_q[g]),
      .data_next  (cell_next[g]),
      .read_part  (read_part[g]),
      .rear_part  (rear_part[g])
    );
  end

  assign found = found_chain[DEPTH];

  // At most one cell drives a nonzero read or rear contribution.
  logic [WIDTH-1:0] read_sel;
  logic [WIDTH-1:0] rear_sel;
  always_comb begin
    read_sel = '0;
    rear_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_sel = read_sel | read_part[i];
      rear_sel = rear_sel | rear_part[i];
    end
  end

  logic [WIDTH-1:0] front_sel;
  assign front_sel = (count_nxt != '0) ? cell_next[0] : '0;

  // Result register.
  logic               out_valid_r;
  logic               out_ok_r;
  logic [WIDTH-1:0]   out_read_r;
  logic [WIDTH-1:0]   out_front_r;
  logic [WIDTH-1:0]   out_rear_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r    <= ok;
      out_read_r  <= (op == OP_READ) ? read_sel : '0;
      out_front_r <= front_sel;
      out_rear_r  <= rear_sel;
      out_count_r <= count_nxt;
      out_empty_r <= count_nxt == '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_empty_r, out_count_r, out_rear_r, out_front_r,
                       out_read_r, out_ok_r};

endmodule
`default_nettype wire

>>> tb/bounded_deque_engine_unit_tb.sv
// Self-checking testbench for bounded_deque_engine_unit: directed corner cases, then random
// command streams with random idling on both stream sides and one long output stall.
// Depends on dqe_pkg and the deque engine RTL only.
module bounded_deque_engine_unit_tb;
  import dqe_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int LONG_HOLD = 80;       // cycles the result side refuses during the pressure test
  localparam int DRAIN_CYCLES = 8;     // quiet cycles after the last result
  localparam int TIMEOUT = 2_000_000;  // far beyond the slowest correct run

  typedef struct packed {
    logic             ok;
    logic [WIDTH-1:0] read_value;
    logic [WIDTH-1:0] front_value;
    logic [WIDTH-1:0] rear_value;
    logic [CNT_W-1:0] count;
    logic             empty_res;
  } deque_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;

  // Mirror of the deque contents, kept as a ring with a head position and a count.
  logic [WIDTH-1:0] ring_words [DEPTH];
  logic [POS_W-1:0] head_pos = '0;
  logic [CNT_W-1:0] live_count = '0;

  deque_result_t expected_results[$];
  deque_result_t want_result;
  deque_result_t got_result;

  int mismatch_count = 0;
  int commands_sent = 0;
  int results_checked = 0;
  int refused_pushes = 0;
  int delete_hits = 0;
  int full_reached = 0;
  int input_stall_cycles = 0;

  int valid_idle_pct = 25;
  int ready_idle_pct = 25;
  int ready_wait = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  bounded_deque_engine_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    #TIMEOUT;
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int draw_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int slot_at(int offset);
    return (int'(head_pos) + offset) % DEPTH;
  endfunction

  // Applies one command to the mirror and returns the result the block must produce.
  function automatic deque_result_t apply_command(input logic [OP_W-1:0] op,
                                                  input logic [WIDTH-1:0] value,
                                                  input logic [INDEX_W-1:0] index);
    deque_result_t res;
    int hit;
    res = '0;
    hit = -1;
    case (op)
      OP_PUSH_FRONT: begin
        if (live_count < DEPTH) begin
          head_pos = POS_W'((int'(head_pos) + DEPTH - 1) % DEPTH);
          ring_words[head_pos] = value;
          live_count++;
          res.ok = 1'b1;
        end else begin
          refused_pushes++;
        end
      end
      OP_PUSH_REAR: begin
        if (live_count < DEPTH) begin
          ring_words[slot_at(int'(live_count))] = value;
          live_count++;
          res.ok = 1'b1;
        end else begin
          refused_pushes++;
        end
      end
      OP_POP_FRONT: begin
        if (live_count != 0) begin
          head_pos = POS_W'(slot_at(1));
          live_count--;
          res.ok = 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (live_count != 0) begin
          live_count--;
          res.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        // First match from the front; later elements move up one place.
        for (int i = 0; i < live_count; i++) begin
          if (hit < 0 && ring_words[slot_at(i)] == value) hit = i;
        end
        if (hit >= 0) begin
          for (int j = hit; j + 1 < live_count; j++) begin
            ring_words[slot_at(j)] = ring_words[slot_at(j + 1)];
          end
          live_count--;
          res.ok = 1'b1;
          delete_hits++;
        end
      end
      OP_READ: begin
        if (index < live_count) begin
          res.read_value = ring_words[slot_at(int'(index))];
          res.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        live_count = '0;
        head_pos = '0;
        res.ok = 1'b1;
      end
      OP_PEEK: begin
        res.ok = 1'b1;
      end
      default: begin
        res.ok = 1'b1;
      end
    endcase
    if (live_count == DEPTH && res.ok && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR)) begin
      full_reached++;
    end
    res.count = live_count;
    res.empty_res = (live_count == 0);
    if (live_count != 0) begin
      res.front_value = ring_words[slot_at(0)];
      res.rear_value = ring_words[slot_at(int'(live_count) - 1)];
    end
    return res;
  endfunction

  // Offers one command, holds it until the transfer, then records its expected result.
  // Valid stays high on return so that a following command can go out back to back.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [WIDTH-1:0] value,
                              input logic [INDEX_W-1:0] index);
    int gap;
    gap = draw_gap(valid_idle_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, index, value, op};
    @(posedge clk);
    while (!in_tready) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    expected_results.push_back(apply_command(op, value, index));
    commands_sent++;
  endtask

  function automatic logic [WIDTH-1:0] pick_value();
    if ($urandom_range(0, 3) != 0) return $urandom;
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return 32'h0000_0001;
      3: return 32'h8000_0000;
      default: return 32'h0000_0042;
    endcase
  endfunction

  // One random command; push_pct steers the fill level. Deletes mostly target a
  // stored word and reads mostly a live index, so both hit as well as miss.
  task automatic random_command(input int push_pct);
    logic [OP_W-1:0] op;
    logic [WIDTH-1:0] value;
    logic [INDEX_W-1:0] index;
    int s;
    value = pick_value();
    index = INDEX_W'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < push_pct) begin
      op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    end else begin
      s = $urandom_range(0, 99);
      if (s < 36) begin
        op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
      end else if (s < 61) begin
        op = OP_DELETE;
        if (live_count != 0 && $urandom_range(0, 3) != 0) begin
          value = ring_words[slot_at($urandom_range(0, int'(live_count) - 1))];
        end
      end else if (s < 86) begin
        op = OP_READ;
        if (live_count != 0 && $urandom_range(0, 4) != 0) begin
          index = INDEX_W'($urandom_range(0, int'(live_count) - 1));
        end
      end else if (s < 99) begin
        op = OP_PEEK;
      end else begin
        op = OP_CLEAR;
      end
    end
    send_command(op, value, index);
  endtask

  // Result side: random ready gaps, plus a long hold when the pressure test asks.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (ready_wait > 0) begin
      ready_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      ready_wait = draw_gap(ready_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [WIDTH-1:0] want_v,
                             input logic [WIDTH-1:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t: result %0d %s: expected %h actual %h", $time, results_checked,
               name, want_v, got_v);
    end
  endtask

  // Compares every result transfer with the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none actual %h", $time, out_tdata);
      end else begin
        want_result = expected_results.pop_front();
        got_result.ok = out_tdata[0];
        got_result.read_value = out_tdata[32:1];
        got_result.front_value = out_tdata[64:33];
        got_result.rear_value = out_tdata[96:65];
        got_result.count = out_tdata[101:97];
        got_result.empty_res = out_tdata[102];
        check_field("ok", want_result.ok, got_result.ok);
        check_field("read_value", want_result.read_value, got_result.read_value);
        check_field("front_value", want_result.front_value, got_result.front_value);
        check_field("rear_value", want_result.rear_value, got_result.rear_value);
        check_field("count", want_result.count, got_result.count);
        check_field("empty_res", want_result.empty_res, got_result.empty_res);
        results_checked++;
      end
    end
  end

  // Pops, delete and read on an empty deque must all fail without effect.
  task automatic test_empty_deque();
    send_command(OP_POP_FRONT, '0, '0);
    send_command(OP_POP_REAR, '0, '0);
    send_command(OP_DELETE, '0, '0);
    send_command(OP_READ, '0, '0);
  endtask

  // Fills to capacity from both ends with extreme and repeated words, then checks
  // refused pushes, reads at the last index, deletes with and without a match,
  // pops, peek and clear.
  task automatic test_full_deque();
    logic [WIDTH-1:0] pattern [6];
    pattern = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
                32'h5A5A_5A5A, 32'hA5A5_A5A5};
    for (int k = 0; k < DEPTH; k++) begin
      send_command(k[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, pattern[k % 6], '0);
    end
    send_command(OP_PUSH_FRONT, 32'h1111_1111, '0);
    send_command(OP_PUSH_REAR, 32'h2222_2222, '0);
    send_command(OP_READ, '0, 4'hF);
    send_command(OP_DELETE, 32'h8000_0000, '0);
    send_command(OP_DELETE, 32'h1234_5678, '0);
    send_command(OP_READ, '0, 4'hF);
    send_command(OP_POP_FRONT, '0, '0);
    send_command(OP_POP_REAR, '0, '0);
    send_command(OP_PEEK, '0, '0);
    send_command(OP_CLEAR, '0, '0);
  endtask

  task automatic test_random_mix(input int n, input int push_pct);
    for (int k = 0; k < n; k++) random_command(push_pct);
  endtask

  // No idling on either side: one command per cycle.
  task automatic test_back_to_back();
    valid_idle_pct = 0;
    ready_idle_pct = 0;
    test_random_mix(150, 50);
    valid_idle_pct = 25;
    ready_idle_pct = 25;
  endtask

  // The result side stops for a long stretch while commands keep coming, so the
  // output register fills and the block must hold off its input.
  task automatic test_output_backpressure();
    valid_idle_pct = 0;
    hold_request = 1'b1;
    test_random_mix(40, 50);
    valid_idle_pct = 25;
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) ring_words[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_deque();
    test_full_deque();
    test_random_mix(300, 70);
    test_output_backpressure();
    valid_idle_pct = 50;
    ready_idle_pct = 10;
    test_random_mix(300, 45);
    test_back_to_back();
    valid_idle_pct = 10;
    ready_idle_pct = 50;
    test_random_mix(250, 25);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands and checked %0d results: %0d refused pushes, %0d deletes found",
             commands_sent, results_checked, refused_pushes, delete_hits);
    $display("their word, capacity reached %0d times, input held off for %0d cycles.",
             full_reached, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> bounded_deque_engine_unit.f
design/dqe_pkg.sv
design/dqe_cell.sv
design/bounded_deque_engine_unit.sv
tb/bounded_deque_engine_unit_tb.sv
